@@ hw/rtl/rau_pkg.sv @@
// Package with shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
   localparam int unsigned WORD_W = 64;
   localparam int unsigned CMD_W  = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_NORM = 3'd0,
      CMD_MUL  = 3'd1,
      CMD_DIV  = 3'd2,
      CMD_ADD  = 3'd3,
      CMD_SUB  = 3'd4,
      CMD_EQ   = 3'd5,
      CMD_QUOT = 3'd6,
      CMD_NONE = 3'd7
   } cmd_type;

   // Request to the shared divider and its answer.
   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] quot;
      logic [WORD_W-1:0] rem;
   } div_rsp_type;
endpackage

@@ hw/rtl/rau_divider.sv @@
// Shared unsigned 64-bit restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rau_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::div_req_type div_req,
   output rau_pkg::div_rsp_type div_rsp
);
   import rau_pkg::*;

   logic [WORD_W-1:0] quot_ff, quot_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] dsr_ff, dsr_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   diff;

   // One shift and subtract step per cycle.
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[WORD_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      if (div_req.start) begin
         quot_in = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = 7'(WORD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[WORD_W]) begin
            rem_in  = trial[WORD_W-1:0];
            quot_in = {quot_ff[WORD_W-2:0], 1'b0};
         end else begin
            rem_in  = diff[WORD_W-1:0];
            quot_in = {quot_ff[WORD_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;
endmodule

@@ hw/rtl/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: sequencer, multiplier and result register.
//
// Usage: present command and two fractions on the req_ channel; one result
// transfer per request leaves on the rsp_ channel. req_stall is high from the
// accepting edge until the result has been taken, so one request is in work.
// Each operand, and then each fraction result, is normalized: sign to the
// numerator, then reduction by the Euclidean gcd, then two reducing divisions.
// Every gcd step and every division runs on one shared bit-serial divider,
// so the time a request takes depends on the gcd step counts of its values.
// Products are formed by one 33 by 33 signed multiplier reused for four products in turn.
// Synchronous reset returns the sequencer to idle and drops rsp_valid.
// When the receiver stalls, the result stays on the rsp_ ports unchanged and
// no new request is accepted until it is transferred.
`timescale 1ns / 1ps
module rational_arithmetic_unit #(
   parameter int unsigned OPERAND_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic signed [31:0] req_num_a,
   input  logic signed [31:0] req_den_a,
   input  logic signed [31:0] req_num_b,
   input  logic signed [31:0] req_den_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [63:0] rsp_res_num,
   output logic [62:0] rsp_res_den,
   output logic        rsp_res_valid,
   output logic        rsp_is_equal
);
   import rau_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_NSTRT = 11'b00000000010,
      ST_GCD   = 11'b00000000100,
      ST_GWAIT = 11'b00000001000,
      ST_RDN   = 11'b00000010000,
      ST_RDD   = 11'b00000100000,
      ST_MUL   = 11'b00001000000,
      ST_COMB  = 11'b00010000000,
      ST_QUOT  = 11'b00100000000,
      ST_QWAIT = 11'b01000000000,
      ST_OUT   = 11'b10000000000
   } state_type;

   // Normalization pass: first operand a, then b, then the result.
   typedef enum logic [1:0] {
      P_A   = 2'd0,
      P_B   = 2'd1,
      P_RES = 2'd2
   } pass_type;

   state_type         state_ff, state_in;
   pass_type          pass_ff, pass_in;
   cmd_type           cmd_ff, cmd_in;
   logic [WORD_W-1:0] na_ff, na_in, da_ff, da_in, nb_ff, nb_in, db_ff, db_in;
   logic [WORD_W-1:0] rn_ff, rn_in, rd_ff, rd_in;
   logic [WORD_W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [WORD_W-1:0] mag_ff, mag_in, den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [WORD_W-1:0] p_ff [4];
   logic [WORD_W-1:0] p_in [4];
   logic [2:0]        mstep_ff, mstep_in;
   logic [WORD_W-1:0] on_ff, on_in;
   logic [62:0]       od_ff, od_in;
   logic              ov_ff, ov_in;
   logic              oe_ff, oe_in;
   logic              busy_ff, busy_in;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic [32:0]       mul_a, mul_b;
   logic [WORD_W-1:0] mul_p;
   logic [WORD_W-1:0] cur_n, cur_d, nd_n, nd_d;

   rau_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Keep the low OPERAND_WIDTH bits and sign-extend them.
   function automatic logic [WORD_W-1:0] sext_op(input logic [31:0] v);
      logic [WORD_W-1:0] r;
      r = {{WORD_W{v[OPERAND_WIDTH-1]}}};
      r[OPERAND_WIDTH-1:0] = v[OPERAND_WIDTH-1:0];
      return r;
   endfunction

   // Shared multiplier: normalized values reach a magnitude of 2^31, so they take 33 signed bits.
   assign mul_p = 64'($signed(mul_a) * $signed(mul_b));

   // Current fraction under normalization, with sign moved to the numerator.
   always_comb begin
      unique case (pass_ff)
         P_A:     begin cur_n = na_ff; cur_d = da_ff; end
         P_B:     begin cur_n = nb_ff; cur_d = db_ff; end
         default: begin cur_n = rn_ff; cur_d = rd_ff; end
      endcase
      nd_n = cur_d[WORD_W-1] ? (WORD_W'(0) - cur_n) : cur_n;
      nd_d = cur_d[WORD_W-1] ? (WORD_W'(0) - cur_d) : cur_d;
   end

   // Multiplier operand selection per product step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (mstep_ff)
         3'd0:    begin mul_a = na_ff[32:0]; mul_b = nb_ff[32:0]; end
         3'd1:    begin mul_a = da_ff[32:0]; mul_b = db_ff[32:0]; end
         3'd2:    begin mul_a = na_ff[32:0]; mul_b = db_ff[32:0]; end
         3'd3:    begin mul_a = nb_ff[32:0]; mul_b = da_ff[32:0]; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd_in   = cmd_ff;
      na_in = na_ff; da_in = da_ff; nb_in = nb_ff; db_in = db_ff;
      rn_in = rn_ff; rd_in = rd_ff;
      gx_in = gx_ff; gy_in = gy_ff;
      mag_in = mag_ff; den_in = den_ff; neg_in = neg_ff;
      p_in = p_ff;
      mstep_in = mstep_ff;
      on_in = on_ff; od_in = od_ff; ov_in = ov_ff; oe_in = oe_ff;
      busy_in = busy_ff;
      div_req = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !busy_ff) begin
               cmd_in  = cmd_type'(req_command);
               na_in   = sext_op(req_num_a);
               da_in   = sext_op(req_den_a);
               nb_in   = sext_op(req_num_b);
               db_in   = sext_op(req_den_b);
               pass_in = P_A;
               busy_in = 1'b1;
               state_in = ST_NSTRT;
            end
         end
         ST_NSTRT: begin
            // Sign to numerator, start gcd on magnitude and denominator.
            neg_in = nd_n[WORD_W-1];
            mag_in = nd_n[WORD_W-1] ? (WORD_W'(0) - nd_n) : nd_n;
            den_in = nd_d;
            gx_in  = nd_n[WORD_W-1] ? (WORD_W'(0) - nd_n) : nd_n;
            gy_in  = nd_d;
            state_in = ST_GCD;
         end
         ST_GCD: begin
            if (den_ff == '0) begin
               mag_in = '0;
               neg_in = 1'b0;
               gy_in  = 64'd1;
               state_in = ST_RDD;
               div_req.start = 1'b1;
               div_req.dividend = '0;
               div_req.divisor  = 64'd1;
            end else if (gx_ff == '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = mag_ff;
               div_req.divisor  = gy_ff;
               state_in = ST_RDN;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = gy_ff;
               div_req.divisor  = gx_ff;
               state_in = ST_GWAIT;
            end
         end
         ST_GWAIT: begin
            if (div_rsp.done) begin
               gy_in = gx_ff;
               gx_in = div_rsp.rem;
               state_in = ST_GCD;
            end
         end
         ST_RDN: begin
            if (div_rsp.done) begin
               mag_in = div_rsp.quot;
               div_req.start    = 1'b1;
               div_req.dividend = den_ff;
               div_req.divisor  = gy_ff;
               state_in = ST_RDD;
            end
         end
         ST_RDD: begin
            if (div_rsp.done) begin
               // Store normalized fraction of this pass.
               unique case (pass_ff)
                  P_A: begin
                     na_in = neg_ff ? (WORD_W'(0) - mag_ff) : mag_ff;
                     da_in = div_rsp.quot;
                     pass_in = P_B;
                     state_in = ST_NSTRT;
                  end
                  P_B: begin
                     nb_in = neg_ff ? (WORD_W'(0) - mag_ff) : mag_ff;
                     db_in = div_rsp.quot;
                     mstep_in = 3'd0;
                     state_in = ST_MUL;
                  end
                  default: begin
                     on_in = neg_ff ? (WORD_W'(0) - mag_ff) : mag_ff;
                     od_in = div_rsp.quot[62:0];
                     ov_in = div_rsp.quot != '0;
                     oe_in = 1'b0;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_MUL: begin
            p_in[mstep_ff[1:0]] = mul_p;
            mstep_in = mstep_ff + 3'd1;
            if (mstep_ff == 3'd3) state_in = ST_COMB;
         end
         ST_COMB: begin
            // p0 = na*nb, p1 = da*db, p2 = na*db, p3 = nb*da.
            pass_in = P_RES;
            state_in = ST_NSTRT;
            unique case (cmd_ff)
               CMD_NORM: begin rn_in = na_ff; rd_in = da_ff; end
               CMD_MUL:  begin rn_in = p_ff[0]; rd_in = p_ff[1]; end
               CMD_DIV:  begin rn_in = p_ff[2]; rd_in = p_ff[3]; end
               CMD_ADD:  begin rn_in = p_ff[2] + p_ff[3]; rd_in = p_ff[1]; end
               CMD_SUB:  begin rn_in = p_ff[2] - p_ff[3]; rd_in = p_ff[1]; end
               CMD_EQ: begin
                  on_in = '0; od_in = '0; ov_in = 1'b0;
                  oe_in = ((da_ff == '0) == (db_ff == '0)) && (p_ff[2] == p_ff[3]);
                  state_in = ST_OUT;
               end
               CMD_QUOT: begin
                  neg_in = na_ff[WORD_W-1];
                  state_in = ST_QUOT;
               end
               default: begin
                  on_in = '0; od_in = '0; ov_in = 1'b0; oe_in = 1'b0;
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_QUOT: begin
            div_req.start    = 1'b1;
            div_req.dividend = neg_ff ? (WORD_W'(0) - na_ff) : na_ff;
            div_req.divisor  = da_ff;
            state_in = ST_QWAIT;
         end
         ST_QWAIT: begin
            if (div_rsp.done) begin
               on_in = (da_ff == '0) ? '0 :
                       (neg_ff ? (WORD_W'(0) - div_rsp.quot) : div_rsp.quot);
               od_in = 63'd1; ov_in = 1'b1; oe_in = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               busy_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         pass_ff  <= P_A;
         mstep_ff <= '0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         pass_ff  <= pass_in;
         mstep_ff <= mstep_in;
      end
      cmd_ff <= cmd_in;
      na_ff <= na_in; da_ff <= da_in; nb_ff <= nb_in; db_ff <= db_in;
      rn_ff <= rn_in; rd_ff <= rd_in;
      gx_ff <= gx_in; gy_ff <= gy_in;
      mag_ff <= mag_in; den_ff <= den_in; neg_ff <= neg_in;
      p_ff <= p_in;
      on_ff <= on_in; od_ff <= od_in; ov_ff <= ov_in; oe_ff <= oe_in;
   end

   assign req_stall     = busy_ff;
   assign rsp_valid     = (state_ff == ST_OUT);
   assign rsp_res_num   = on_ff;
   assign rsp_res_den   = od_ff;
   assign rsp_res_valid = ov_ff;
   assign rsp_is_equal  = oe_ff;
endmodule
